FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the projection radius block
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// whenever ante holds, cons must hold in the same cycle
`define ASSERT_IMPLIES(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

// cond must never hold
`define ASSERT_NEVER(label, clk_s, rstn_s, cond) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
        else $error("assertion failed: forbidden condition seen");

`endif

FILE: rtl/sapr_pkg.sv
// ---------------------------------------------------------------------------
// sapr_pkg
// widths, kind codes and the queued word type of the projection radius block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sapr_pkg;

    localparam int KIND_W   = 2;
    localparam int IDX_W    = 3;
    localparam int COORD_W  = 24;
    localparam int AXIS_W   = 18;
    localparam int RADIUS_W = 27;

    // offset, product, three-term sum and max-min difference widths
    localparam int OFF_W  = COORD_W + 1;
    localparam int PROD_W = OFF_W + AXIS_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int DIFF_W = SUM_W + 1;

    // halve and drop sixteen fraction bits
    localparam int RADIUS_SHIFT = 17;

    localparam int VERTEX_COUNT_DEF = 6;

    localparam logic [KIND_W-1:0] KIND_LOAD_VERTEX = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_CENTER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY       = 2'd2;

    // one classified word; queries carry the axis sign-extended in d_x..d_z
    typedef struct packed {
        logic [KIND_W-1:0]         op;
        logic [IDX_W-1:0]          idx;
        logic signed [COORD_W-1:0] d_x;
        logic signed [COORD_W-1:0] d_y;
        logic signed [COORD_W-1:0] d_z;
    } sapr_word_t;

endpackage

FILE: rtl/sapr_front.sv
// ---------------------------------------------------------------------------
// sapr_front
// accepts words, drops those with no effect, queues the rest for the back end
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sapr_front #(
    parameter int VERTEX_COUNT = sapr_pkg::VERTEX_COUNT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic [sapr_pkg::KIND_W-1:0]          kind,
    input  logic [sapr_pkg::IDX_W-1:0]           vertex_index,
    input  logic signed [sapr_pkg::COORD_W-1:0]  coord_x,
    input  logic signed [sapr_pkg::COORD_W-1:0]  coord_y,
    input  logic signed [sapr_pkg::COORD_W-1:0]  coord_z,
    input  logic signed [sapr_pkg::AXIS_W-1:0]   axis_x,
    input  logic signed [sapr_pkg::AXIS_W-1:0]   axis_y,
    input  logic signed [sapr_pkg::AXIS_W-1:0]   axis_z,
    output logic                                 q_valid,
    output sapr_pkg::sapr_word_t                 q_word,
    input  logic                                 q_pop
);

    import sapr_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sapr_word_t       q_mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic       keep;
    logic       push;
    sapr_word_t word_in;

    // vertex loads beyond the store and the unused kind have no effect
    always_comb
    begin
        keep = 1'b0;
        case (kind)
            KIND_LOAD_VERTEX: keep = (32'(vertex_index) < VERTEX_COUNT);
            KIND_LOAD_CENTER: keep = 1'b1;
            KIND_QUERY:       keep = 1'b1;
            default:          keep = 1'b0;
        endcase
    end

    always_comb
    begin
        word_in.op  = kind;
        word_in.idx = vertex_index;
        if (kind == KIND_QUERY)
        begin
            word_in.d_x = COORD_W'(axis_x);
            word_in.d_y = COORD_W'(axis_y);
            word_in.d_z = COORD_W'(axis_z);
        end
        else
        begin
            word_in.d_x = coord_x;
            word_in.d_y = coord_y;
            word_in.d_z = coord_z;
        end
    end

    assign item_stall = (count_reg == CNT_W'(DEPTH));
    assign push       = item_valid && !item_stall && keep;
    assign q_valid    = (count_reg != '0);
    assign q_word     = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= word_in;
        end
    end

    `ASSERT_NEVER(a_count_max, clk, rst_n, count_reg > CNT_W'(DEPTH))
    `ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, q_pop, count_reg != '0)
    `ASSERT_IMPLIES(a_empty_ptrs, clk, rst_n, count_reg == '0, wr_ptr_reg == rd_ptr_reg)

endmodule

FILE: rtl/sapr_back.sv
// ---------------------------------------------------------------------------
// sapr_back
// holds vertices and centre, sweeps them per query through a dot-product pipe
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sapr_back #(
    parameter int VERTEX_COUNT = sapr_pkg::VERTEX_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  sapr_pkg::sapr_word_t          q_word,
    output logic                          q_pop,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [sapr_pkg::RADIUS_W-1:0] radius
);

    import sapr_pkg::*;

    localparam int VIDX_W = $clog2(VERTEX_COUNT);
    localparam logic [VIDX_W-1:0] VIDX_LAST = VIDX_W'(VERTEX_COUNT - 1);
    localparam int SHIFTED_W = DIFF_W - RADIUS_SHIFT;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    logic signed [COORD_W-1:0] vx_reg [VERTEX_COUNT];
    logic signed [COORD_W-1:0] vy_reg [VERTEX_COUNT];
    logic signed [COORD_W-1:0] vz_reg [VERTEX_COUNT];
    logic signed [COORD_W-1:0] cx_reg;
    logic signed [COORD_W-1:0] cy_reg;
    logic signed [COORD_W-1:0] cz_reg;
    logic signed [AXIS_W-1:0]  ax_reg;
    logic signed [AXIS_W-1:0]  ay_reg;
    logic signed [AXIS_W-1:0]  az_reg;

    logic [VIDX_W-1:0] vidx_reg;
    logic [31:0]       wr_idx_wide;

    // pipe: offsets, products, sum, running min and max
    logic                     a_vld_reg, a_first_reg, a_last_reg;
    logic                     b_vld_reg, b_first_reg, b_last_reg;
    logic                     c_vld_reg, c_first_reg, c_last_reg;
    logic signed [OFF_W-1:0]  off_x_reg, off_y_reg, off_z_reg;
    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg, prod_z_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  lo_reg, hi_reg;
    logic                     pipe_busy;

    logic signed [DIFF_W-1:0] diff;
    logic [SHIFTED_W-1:0]     shifted;
    logic [RADIUS_W-1:0]      radius_calc;
    logic                     fire;

    logic                     result_valid_reg;
    logic [RADIUS_W-1:0]      radius_reg;

    assign q_pop       = (state_reg == ST_IDLE) && q_valid;
    assign wr_idx_wide = 32'(q_word.idx);
    assign pipe_busy   = a_vld_reg || b_vld_reg || c_vld_reg;

    // finish: halve the spread, floor to Q.16, saturate
    assign diff    = DIFF_W'(hi_reg) - DIFF_W'(lo_reg);
    assign shifted = SHIFTED_W'(diff >>> RADIUS_SHIFT);
    assign radius_calc = (|shifted[SHIFTED_W-1:RADIUS_W]) ? '1 : shifted[RADIUS_W-1:0];
    assign fire = (state_reg == ST_FINISH) && (!result_valid_reg || !result_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_pop && (q_word.op == KIND_QUERY))
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (vidx_reg == VIDX_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (c_vld_reg && c_last_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            vidx_reg         <= '0;
            a_vld_reg        <= 1'b0;
            b_vld_reg        <= 1'b0;
            c_vld_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SWEEP)
            begin
                vidx_reg <= vidx_reg + 1'b1;
            end
            else
            begin
                vidx_reg <= '0;
            end
            a_vld_reg <= (state_reg == ST_SWEEP);
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            if (fire)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // stores and datapath
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            case (q_word.op)
                KIND_LOAD_VERTEX:
                begin
                    vx_reg[wr_idx_wide[VIDX_W-1:0]] <= q_word.d_x;
                    vy_reg[wr_idx_wide[VIDX_W-1:0]] <= q_word.d_y;
                    vz_reg[wr_idx_wide[VIDX_W-1:0]] <= q_word.d_z;
                end
                KIND_LOAD_CENTER:
                begin
                    cx_reg <= q_word.d_x;
                    cy_reg <= q_word.d_y;
                    cz_reg <= q_word.d_z;
                end
                KIND_QUERY:
                begin
                    ax_reg <= q_word.d_x[AXIS_W-1:0];
                    ay_reg <= q_word.d_y[AXIS_W-1:0];
                    az_reg <= q_word.d_z[AXIS_W-1:0];
                end
                default:
                begin
                end
            endcase
        end

        a_first_reg <= (vidx_reg == '0);
        a_last_reg  <= (vidx_reg == VIDX_LAST);
        off_x_reg   <= OFF_W'(vx_reg[vidx_reg]) - OFF_W'(cx_reg);
        off_y_reg   <= OFF_W'(vy_reg[vidx_reg]) - OFF_W'(cy_reg);
        off_z_reg   <= OFF_W'(vz_reg[vidx_reg]) - OFF_W'(cz_reg);

        b_first_reg <= a_first_reg;
        b_last_reg  <= a_last_reg;
        prod_x_reg  <= PROD_W'(off_x_reg) * PROD_W'(ax_reg);
        prod_y_reg  <= PROD_W'(off_y_reg) * PROD_W'(ay_reg);
        prod_z_reg  <= PROD_W'(off_z_reg) * PROD_W'(az_reg);

        c_first_reg <= b_first_reg;
        c_last_reg  <= b_last_reg;
        sum_reg     <= SUM_W'(prod_x_reg) + SUM_W'(prod_y_reg) + SUM_W'(prod_z_reg);

        if (c_vld_reg)
        begin
            if (c_first_reg || (sum_reg < lo_reg))
            begin
                lo_reg <= sum_reg;
            end
            if (c_first_reg || (sum_reg > hi_reg))
            begin
                hi_reg <= sum_reg;
            end
        end

        if (fire)
        begin
            radius_reg <= radius_calc;
        end
    end

    assign result_valid = result_valid_reg;
    assign radius       = radius_reg;

    `ASSERT_IMPLIES(a_pop_idle, clk, rst_n, q_pop, state_reg == ST_IDLE)
    `ASSERT_IMPLIES(a_last_drain, clk, rst_n, c_vld_reg && c_last_reg, state_reg == ST_DRAIN)
    `ASSERT_IMPLIES(a_finish_empty, clk, rst_n, state_reg == ST_FINISH, !pipe_busy)

endmodule

FILE: rtl/separating_axis_projection_radius.sv
// ---------------------------------------------------------------------------
// separating_axis_projection_radius
// projected radius of a stored rigid body onto a query axis
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// Words enter on the item channel (valid/stall) and are classified by a front
// end into a two-word queue; a back end takes them in order. Vertex and centre
// loads are stored as the back end takes them and give no result; vertex
// loads past the store and the unused kind are dropped on entry. A query
// sweeps the stored vertices through one dot-product pipe (offset, three
// multipliers, sum, running min/max), one vertex a cycle, and occupies the
// back end from its pop from the queue through the sweep, the draining of
// the pipe stages and a finishing state that halves the spread. Loads queued
// behind a query wait for it to finish. The radius is held in an output
// register, so the block keeps taking words while a result waits; a second
// query only stalls in its finishing state until that result is taken.
// Stores have no reset, so a query must follow the loads of every vertex and
// the centre.

module separating_axis_projection_radius #(
    parameter int VERTEX_COUNT = sapr_pkg::VERTEX_COUNT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // item channel
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic [sapr_pkg::KIND_W-1:0]          kind,
    input  logic [sapr_pkg::IDX_W-1:0]           vertex_index,
    input  logic signed [sapr_pkg::COORD_W-1:0]  coord_x,
    input  logic signed [sapr_pkg::COORD_W-1:0]  coord_y,
    input  logic signed [sapr_pkg::COORD_W-1:0]  coord_z,
    input  logic signed [sapr_pkg::AXIS_W-1:0]   axis_x,
    input  logic signed [sapr_pkg::AXIS_W-1:0]   axis_y,
    input  logic signed [sapr_pkg::AXIS_W-1:0]   axis_z,
    // result channel
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [sapr_pkg::RADIUS_W-1:0]        radius
);

    import sapr_pkg::*;

    // queue between front and back end
    logic       q_valid;
    logic       q_pop;
    sapr_word_t q_word;

    // accepts, filters and queues words
    sapr_front #(
        .VERTEX_COUNT (VERTEX_COUNT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .vertex_index (vertex_index),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .axis_x       (axis_x),
        .axis_y       (axis_y),
        .axis_z       (axis_z),
        .q_valid      (q_valid),
        .q_word       (q_word),
        .q_pop        (q_pop)
    );

    // owns the stores, runs the projection sweep, holds the result
    sapr_back #(
        .VERTEX_COUNT (VERTEX_COUNT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_word       (q_word),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .radius       (radius)
    );

endmodule
